// File: src/fitbc_pkg.sv
// Package for the flux interval to bitcell unit: shared codes, defaults,
// state enums and the result item structure. No dependencies.
`default_nettype none

package fitbc_pkg;

   // Defaults for the top-level parameters.
   localparam int unsigned TICKS_PER_CELL_DEF = 80;
   localparam int unsigned MAX_RUN_CELLS_DEF  = 4000;
   localparam int unsigned QUEUE_DEPTH_DEF    = 2;

   // Input item kinds, carried on req_tuser.
   localparam logic OP_FLUX = 1'b0;
   localparam logic OP_END  = 1'b1;

   // Ticks added to the carry by an overflow word.
   localparam logic [32:0] OVF_TICKS = 33'h0_0001_0000;

   // Cells in one result word, and the saturation value of the track total.
   localparam logic [6:0]  WORD_CELLS = 7'd64;
   localparam logic [23:0] TOTAL_MAX  = 24'hFF_FFFF;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV,
      F_PUSH
   } front_state_type;

   typedef enum logic {
      B_IDLE,
      B_RUN
   } back_state_type;

   typedef struct packed {
      logic [63:0] cell_bits;
      logic [6:0]  valid_cells;
      logic        track_end;
      logic [23:0] track_cells;
      logic        last;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: src/flux_interval_to_bitcells_unit.sv
// Top level of the flux interval to bitcell unit: front end, queue, back end.
// Depends on fitbc_pkg, fitbc_front, fitbc_queue and fitbc_back.
//
// Usage: the req_ channel carries one track of 16-bit flux interval words in
// req_tdata, with req_tuser = 0; a zero word is an overflow worth 65536 ticks.
// An item with req_tuser = 1 ends the track. The rsp_ channel returns 64-bit
// words of bitcells, first cell in the most significant bit, with the count of
// valid cells, the track-end flag on rsp_tuser and rsp_tlast on the last result
// that an input item causes. Overflow words cause no result.
// In the front end, an overflow word or a track end is taken in the idle
// state. A nonzero interval holds the front end through the accepting state,
// a state for the reciprocal multiplication that yields the cell count and a
// state that writes the count into the queue and waits while it is full. The
// back end takes a count in its idle state and then packs one full 64-bit word
// per cycle while the result register is free; the queue lets the front end go
// on. A count reaches the result register through the queue and the back end's
// run state, a track end through the queue alone. A stalled receiver holds the
// result register; the back end then stops at its next result, the queue fills
// and req_tready drops. Reset (synchronous, active high) clears the carry, the
// partial word, the cell total and the queue; no clearing pass is needed.
`default_nettype none

module flux_interval_to_bitcells_unit import fitbc_pkg::*; #(
   parameter int unsigned TICKS_PER_CELL = TICKS_PER_CELL_DEF,
   parameter int unsigned MAX_RUN_CELLS  = MAX_RUN_CELLS_DEF,
   parameter int unsigned QUEUE_DEPTH    = QUEUE_DEPTH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,  // [15:0] flux_word
   input  wire logic        req_tuser,  // [0] op
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [95:0]      rsp_tdata,  // [63:0] cell_bits, [70:64] valid_cells,
                                        // [94:71] track_cells, [95] zero
   output logic             rsp_tuser,  // [0] track_end
   output logic             rsp_tlast
);

   localparam int unsigned CELLS_W = $clog2(MAX_RUN_CELLS + 1);

   logic             q_push;
   logic             q_pop;
   logic             q_full;
   logic             q_empty;
   logic [CELLS_W:0] q_wr_data;
   logic [CELLS_W:0] q_rd_data;
   rsp_item_type     rsp_item;

   fitbc_front #(
      .TICKS_PER_CELL (TICKS_PER_CELL),
      .MAX_RUN_CELLS  (MAX_RUN_CELLS),
      .CELLS_W        (CELLS_W)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_op        (req_tuser),
      .req_flux_word (req_tdata),
      .req_ready     (req_tready),
      .q_full        (q_full),
      .q_push        (q_push),
      .q_data        (q_wr_data)
   );

   fitbc_queue #(
      .DATA_W (CELLS_W + 1),
      .DEPTH  (QUEUE_DEPTH)
   ) u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (q_push),
      .wr_data (q_wr_data),
      .full    (q_full),
      .pop     (q_pop),
      .rd_data (q_rd_data),
      .empty   (q_empty)
   );

   fitbc_back #(
      .CELLS_W (CELLS_W)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_data    (q_rd_data),
      .q_pop     (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_item  (rsp_item)
   );

   assign rsp_tdata = {1'b0, rsp_item.track_cells, rsp_item.valid_cells,
                       rsp_item.cell_bits};
   assign rsp_tuser = rsp_item.track_end;
   assign rsp_tlast = rsp_item.last;

endmodule

`default_nettype wire

// File: src/fitbc_queue.sv
// Small flip-flop FIFO between the classifying front and the cell emitter.
// Depends on nothing but its parameters.
`default_nettype none

module fitbc_queue #(
   parameter int unsigned DATA_W = 13,
   parameter int unsigned DEPTH  = 2
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire logic [DATA_W-1:0] wr_data,
   output logic                   full,
   input  wire logic              pop,
   output logic [DATA_W-1:0]      rd_data,
   output logic                   empty
);

   localparam int unsigned PW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CNTW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0]   PTR_LAST = PW'(DEPTH - 1);
   localparam logic [CNTW-1:0] CNT_FULL = CNTW'(DEPTH);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [PW-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNTW-1:0]   count_ff, count_in;

   assign full    = (count_ff == CNT_FULL);
   assign empty   = (count_ff == '0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue written while full");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL) else $error("queue count out of range");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not follow a write");

endmodule

`default_nettype wire

// File: src/fitbc_front.sv
// Front end: accepts input items, folds overflow words into the carry and
// turns an interval into a cell count by a reciprocal multiplication.
// Depends on fitbc_pkg.
`default_nettype none

module fitbc_front import fitbc_pkg::*; #(
   parameter int unsigned TICKS_PER_CELL = TICKS_PER_CELL_DEF,
   parameter int unsigned MAX_RUN_CELLS  = MAX_RUN_CELLS_DEF,
   parameter int unsigned CELLS_W        = $clog2(MAX_RUN_CELLS + 1)
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_op,
   input  wire logic [15:0]        req_flux_word,
   output logic                    req_ready,
   input  wire logic               q_full,
   output logic                    q_push,
   output logic [CELLS_W:0]        q_data
);

   // Below the saturation limit the rounded interval fits in DW bits. A
   // reciprocal rounded up, with SHIFT fraction bits, gives the exact quotient
   // for every dividend of that width.
   localparam logic [63:0] SAT_LIMIT = 64'(MAX_RUN_CELLS) * 64'(TICKS_PER_CELL);
   localparam int unsigned DW    = $clog2(SAT_LIMIT);
   localparam int unsigned SHIFT = DW + $clog2(TICKS_PER_CELL);
   localparam int unsigned MW    = DW + 1;
   localparam int unsigned PW    = DW + MW;
   localparam logic [63:0] RECIP_FULL =
      ((64'd1 << SHIFT) + 64'(TICKS_PER_CELL) - 64'd1) / 64'(TICKS_PER_CELL);
   localparam logic [MW-1:0]      RECIP       = RECIP_FULL[MW-1:0];
   localparam logic [32:0]        HALF        = 33'(TICKS_PER_CELL / 2);
   localparam logic [32:0]        LIMIT       = SAT_LIMIT[32:0];
   localparam logic [CELLS_W-1:0] MAX_CELLS   = CELLS_W'(MAX_RUN_CELLS);
   localparam logic [CELLS_W-1:0] ONE_CELL    = CELLS_W'(1);

   front_state_type    state_ff, state_in;
   logic [31:0]        carry_ff, carry_in;
   logic [DW-1:0]      rem_ff, rem_in;
   logic [CELLS_W-1:0] quo_ff, quo_in;
   logic               sat_ff, sat_in;

   logic [32:0]        carry_sum;
   logic [32:0]        word_sum;
   logic [32:0]        interval;
   logic [32:0]        rounded;
   logic [PW-1:0]      product;
   logic [CELLS_W-1:0] quotient;
   logic [CELLS_W-1:0] cells;

   // The interval saturates at 32 bits before rounding.
   assign carry_sum = {1'b0, carry_ff} + OVF_TICKS;
   assign word_sum  = {1'b0, carry_ff} + {17'd0, req_flux_word};
   assign interval  = word_sum[32] ? 33'h0_FFFF_FFFF : word_sum;
   assign rounded   = interval + HALF;

   assign product   = {{MW{1'b0}}, rem_ff} * {{DW{1'b0}}, RECIP};
   assign quotient  = CELLS_W'(product >> SHIFT);
   assign cells     = sat_ff ? MAX_CELLS : ((quo_ff == '0) ? ONE_CELL : quo_ff);

   always_comb begin
      state_in  = state_ff;
      carry_in  = carry_ff;
      rem_in    = rem_ff;
      quo_in    = quo_ff;
      sat_in    = sat_ff;
      req_ready = 1'b0;
      q_push    = 1'b0;
      q_data    = '0;
      unique case (state_ff)
         F_IDLE: begin
            req_ready = !q_full;
            if (req_valid && !q_full) begin
               if (req_op == OP_END) begin
                  // A pending carry is dropped at the track end.
                  q_push   = 1'b1;
                  q_data   = {1'b1, {CELLS_W{1'b0}}};
                  carry_in = '0;
               end else if (req_flux_word == 16'd0) begin
                  carry_in = carry_sum[32] ? 32'hFFFF_FFFF : carry_sum[31:0];
               end else begin
                  carry_in = '0;
                  rem_in   = rounded[DW-1:0];
                  sat_in   = (rounded >= LIMIT);
                  state_in = F_DIV;
               end
            end
         end
         F_DIV: begin
            // One registered multiplication by the reciprocal of the cell length.
            quo_in   = quotient;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!q_full) begin
               q_push   = 1'b1;
               q_data   = {1'b0, cells};
               state_in = F_IDLE;
            end
         end
         default: begin
            state_in = F_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         carry_ff <= '0;
      end else begin
         state_ff <= state_in;
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      sat_ff  <= sat_in;
   end

   a_busy_not_ready: assert property (@(posedge clock) disable iff (reset)
      state_ff != F_IDLE |-> !req_ready) else $error("front ready while busy");
   a_carry_cleared: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && (req_op == OP_END || req_flux_word != 16'd0)
      |=> carry_ff == '0) else $error("carry not cleared");
   a_div_ends: assert property (@(posedge clock) disable iff (reset)
      state_ff == F_DIV |=> state_ff == F_PUSH)
      else $error("divider did not finish");

endmodule

`default_nettype wire

// File: src/fitbc_back.sv
// Back end: takes cell counts and track ends from the queue, packs cells
// MSB-first into 64-bit words and holds the result register.
// Depends on fitbc_pkg.
`default_nettype none

module fitbc_back import fitbc_pkg::*; #(
   parameter int unsigned CELLS_W = 12
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             q_empty,
   input  wire logic [CELLS_W:0] q_data,
   output logic                  q_pop,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   output rsp_item_type          rsp_item
);

   localparam int unsigned ZW = (CELLS_W > 7) ? CELLS_W : 7;
   localparam logic [63:0] WORD_TOP = 64'h8000_0000_0000_0000;

   back_state_type     state_ff, state_in;
   logic [63:0]        word_ff, word_in;
   logic [5:0]         count_ff, count_in;
   logic [CELLS_W-1:0] zeros_ff, zeros_in;
   logic [23:0]        total_ff, total_in;
   logic               out_valid_ff, out_valid_in;
   rsp_item_type       out_item_ff, out_item_in;

   logic               out_free;
   logic               entry_end;
   logic [CELLS_W-1:0] entry_cells;
   logic [6:0]         space;
   logic [ZW-1:0]      zeros_wide;
   logic [ZW-1:0]      zeros_after;
   logic               full_run;
   logic [5:0]         pos;
   logic [63:0]        word_one;
   logic [24:0]        total_add;
   logic [23:0]        total_run;
   logic [6:0]         padded;
   logic [6:0]         pad_add;
   logic [24:0]        total_pad_sum;
   logic [23:0]        total_pad;
   logic               emit;
   rsp_item_type       emit_item;

   assign out_free    = !out_valid_ff || rsp_ready;
   assign entry_end   = q_data[CELLS_W];
   assign entry_cells = q_data[CELLS_W-1:0];

   assign space       = WORD_CELLS - {1'b0, count_ff};
   assign zeros_wide  = ZW'(zeros_ff);
   assign full_run    = (zeros_wide >= ZW'(space));
   assign zeros_after = zeros_wide - ZW'(space);
   // Valid only when the zeros do not fill the word.
   assign pos         = count_ff + 6'(zeros_ff);
   assign word_one    = word_ff | (WORD_TOP >> pos);

   assign total_add   = {1'b0, total_ff} + 25'(entry_cells);
   assign total_run   = total_add[24] ? TOTAL_MAX : total_add[23:0];

   assign padded        = ({1'b0, count_ff} + 7'd7) & 7'h78;
   assign pad_add       = padded - {1'b0, count_ff};
   assign total_pad_sum = {1'b0, total_ff} + 25'(pad_add);
   assign total_pad     = total_pad_sum[24] ? TOTAL_MAX : total_pad_sum[23:0];

   always_comb begin
      state_in  = state_ff;
      word_in   = word_ff;
      count_in  = count_ff;
      zeros_in  = zeros_ff;
      total_in  = total_ff;
      q_pop     = 1'b0;
      emit      = 1'b0;
      emit_item = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               if (entry_end) begin
                  if (out_free) begin
                     q_pop                 = 1'b1;
                     emit                  = 1'b1;
                     emit_item.cell_bits   = word_ff;
                     emit_item.valid_cells = padded;
                     emit_item.track_end   = 1'b1;
                     emit_item.track_cells = total_pad;
                     emit_item.last        = 1'b1;
                     word_in               = '0;
                     count_in              = '0;
                     total_in              = '0;
                  end
               end else begin
                  q_pop    = 1'b1;
                  zeros_in = entry_cells - 1'b1;
                  total_in = total_run;
                  state_in = B_RUN;
               end
            end
         end
         B_RUN: begin
            if (full_run) begin
               // Zeros fill the rest of the word. It is the item's last
               // result unless the zeros left and the closing one would fill the next word.
               if (out_free) begin
                  emit                  = 1'b1;
                  emit_item.cell_bits   = word_ff;
                  emit_item.valid_cells = WORD_CELLS;
                  emit_item.last        = (zeros_after <= ZW'(62));
                  word_in               = '0;
                  count_in              = '0;
                  zeros_in              = CELLS_W'(zeros_after);
               end
            end else if (pos == 6'd63) begin
               if (out_free) begin
                  emit                  = 1'b1;
                  emit_item.cell_bits   = word_one;
                  emit_item.valid_cells = WORD_CELLS;
                  emit_item.last        = 1'b1;
                  word_in               = '0;
                  count_in              = '0;
                  zeros_in              = '0;
                  state_in              = B_IDLE;
               end
            end else begin
               word_in  = word_one;
               count_in = pos + 1'b1;
               zeros_in = '0;
               state_in = B_IDLE;
            end
         end
         default: begin
            state_in = B_IDLE;
         end
      endcase

      out_valid_in = out_valid_ff;
      out_item_in  = out_item_ff;
      if (emit) begin
         out_valid_in = 1'b1;
         out_item_in  = emit_item;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         word_ff      <= '0;
         count_ff     <= '0;
         zeros_ff     <= '0;
         total_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         word_ff      <= word_in;
         count_ff     <= count_in;
         zeros_ff     <= zeros_in;
         total_ff     <= total_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_item_ff <= out_item_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_item  = out_item_ff;

   a_end_bytes: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_item_ff.track_end
      |-> out_item_ff.valid_cells[2:0] == 3'd0 && out_item_ff.last)
      else $error("track end not byte aligned");
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_item_ff.track_end
      |-> out_item_ff.valid_cells == WORD_CELLS && out_item_ff.track_cells == '0)
      else $error("run result not a full word");
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      emit |-> out_free) else $error("result register overwritten");
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty) else $error("pop from empty queue");

endmodule

`default_nettype wire
